// ----- rtl/core/msp_pkg.sv -----
package msp_pkg;

    // Command codes carried on s_tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ZERO  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_ADDR_W-1:0] CFG_POWER     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIR_POL   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT_EN  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_X    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_Y    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_Z    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_R    = 3'd6;

    // Field widths fixed by the interface
    localparam int AXIS_W   = 2;
    localparam int PORTS    = 4;
    localparam int LIMIT_W  = 4;
    localparam int HP_W     = 20;
    localparam int STEPS_W  = 23;
    localparam int POS_W    = 32;
    localparam int OUT_W    = 64;
    localparam logic [STEPS_W-1:0] STEP_MAX = 23'h7FFFFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [1:0]          op;
        logic [AXIS_W-1:0]   sel;
        logic                neg;
        logic [STEPS_W-1:0]  mag;
        logic [LIMIT_W-1:0]  limits;
    } cmd_t;

    typedef struct packed {
        logic                         power_on;
        logic [PORTS-1:0]             dir_polarity;
        logic [PORTS-1:0]             limit_enable;
        logic [PORTS-1:0][HP_W-1:0]   half_period;
    } cfg_t;

endpackage

// ----- rtl/core/multi_axis_step_pulse_generator.sv -----
// Step/direction pulse generator for stepper axes, one axis moving at a time.
// Input stream s_*: one word per tick or command. s_tuser selects the
// command (tick, start move, zero positions, no-op); s_tdata carries the
// axis, signed step count and sampled limit switch levels.
// Output stream m_*: exactly one word per input word, in order, giving the
// step and direction levels, active axis, drive/busy state, done and limit
// flags, steps completed and the position of the selected axis.
// Config port: cfg_we writes cfg_wdata to register cfg_addr;
// write only while no words are in flight.
// Throughput: one word per cycle while m_tready is high. A word accepted
// passes through the two-entry command queue, then the execution unit
// loads the output register, which drives m_tdata.
// When m_tready is low the output register holds, the queue fills and
// s_tready drops once both queue entries are taken; nothing is lost.
// Reset clears positions, move state and all flags and loads the
// configuration defaults (power off, limit sensing on axes 0 and 1).
module multi_axis_step_pulse_generator #(
    parameter int NUM_AXES        = 4,
    parameter int STEP_COUNT_BITS = 24,
    parameter int TIMER_BITS      = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // axis_sel [1:0], step_count, limit_inputs, zero fill to bytes
    input  logic [((msp_pkg::AXIS_W + STEP_COUNT_BITS + msp_pkg::LIMIT_W + 7) / 8) * 8 - 1:0]
                                                s_tdata,
    // func
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // step_line, dir_line, active_axis[1:0], drive_full, busy_res, move_done,
    // limit_hit, steps_done[22:0], position[31:0], zero fill
    output logic [msp_pkg::OUT_W-1:0]           m_tdata,
    input  logic                                cfg_we,
    input  logic [msp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [msp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import msp_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_not_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on       <= 1'b0;
            cfg_reg.dir_polarity   <= '0;
            cfg_reg.limit_enable   <= 4'd3;
            cfg_reg.half_period[0] <= 20'd100000;
            cfg_reg.half_period[1] <= 20'd150000;
            cfg_reg.half_period[2] <= 20'd100000;
            cfg_reg.half_period[3] <= 20'd30000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_POWER:    cfg_reg.power_on       <= cfg_wdata[0];
                CFG_DIR_POL:  cfg_reg.dir_polarity   <= cfg_wdata[PORTS-1:0];
                CFG_LIMIT_EN: cfg_reg.limit_enable   <= cfg_wdata[PORTS-1:0];
                CFG_HALF_X:   cfg_reg.half_period[0] <= cfg_wdata[HP_W-1:0];
                CFG_HALF_Y:   cfg_reg.half_period[1] <= cfg_wdata[HP_W-1:0];
                CFG_HALF_Z:   cfg_reg.half_period[2] <= cfg_wdata[HP_W-1:0];
                CFG_HALF_R:   cfg_reg.half_period[3] <= cfg_wdata[HP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    msp_front #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    msp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    msp_back #(
        .NUM_AXES   (NUM_AXES),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ----- rtl/core/msp_front.sv -----
module msp_front #(
    parameter int STEP_COUNT_BITS = 24
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // axis_sel [1:0], step_count, limit_inputs, zero fill to bytes
    input  logic [((msp_pkg::AXIS_W + STEP_COUNT_BITS + msp_pkg::LIMIT_W + 7) / 8) * 8 - 1:0]
                                 s_tdata,
    // func
    input  logic [1:0]           s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output msp_pkg::cmd_t        q_cmd
);
    import msp_pkg::*;

    localparam int EXT_W = STEP_COUNT_BITS + STEPS_W;

    logic [STEP_COUNT_BITS-1:0] raw;
    logic [STEP_COUNT_BITS-1:0] raw_abs;
    logic [EXT_W-1:0]           abs_ext;
    logic                       neg;

    // Take the word when the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Split sign and magnitude, saturate to the step counter range
    assign raw     = s_tdata[AXIS_W +: STEP_COUNT_BITS];
    assign neg     = raw[STEP_COUNT_BITS-1];
    assign raw_abs = neg ? (~raw + {{(STEP_COUNT_BITS-1){1'b0}}, 1'b1}) : raw;
    assign abs_ext = EXT_W'(raw_abs);

    always_comb
    begin
        q_cmd.op     = s_tuser;
        q_cmd.sel    = s_tdata[AXIS_W-1:0];
        q_cmd.neg    = neg;
        q_cmd.limits = s_tdata[AXIS_W + STEP_COUNT_BITS +: LIMIT_W];
        if (abs_ext > EXT_W'(STEP_MAX))
        begin
            q_cmd.mag = STEP_MAX;
        end
        else
        begin
            q_cmd.mag = abs_ext[STEPS_W-1:0];
        end
    end

endmodule

// ----- rtl/core/msp_queue.sv -----
module msp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  msp_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output msp_pkg::cmd_t  head_cmd,
    output logic           full,
    output logic           not_empty
);
    import msp_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/msp_back.sv -----
module msp_back #(
    parameter int NUM_AXES   = 4,
    parameter int TIMER_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  msp_pkg::cfg_t               cfg,
    input  logic                        q_not_empty,
    input  msp_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [msp_pkg::OUT_W-1:0]   m_tdata
);
    import msp_pkg::*;

    logic [POS_W-1:0]      pos_reg [NUM_AXES];
    logic [POS_W-1:0]      pos_next [NUM_AXES];
    logic                  moving_reg, moving_next;
    logic                  high_reg, high_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [STEPS_W-1:0]    target_reg, target_next;
    logic [STEPS_W-1:0]    completed_reg, completed_next;
    logic [AXIS_W-1:0]     axis_reg, axis_next;
    logic                  neg_reg, neg_next;
    logic                  limit_reg, limit_next;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    logic [TIMER_BITS-1:0] half;
    logic [STEPS_W-1:0]    completed_inc;
    logic [POS_W-1:0]      pos_delta;
    logic                  finish;
    logic                  done;
    logic [POS_W-1:0]      pos_out;

    // Execute when a word waits and the output slot is free or draining
    assign q_pop    = q_not_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Half period of the moving axis, zero taken as one
    always_comb
    begin
        half = TIMER_BITS'(cfg.half_period[axis_reg]);
        if (half == '0)
        begin
            half = {{(TIMER_BITS-1){1'b0}}, 1'b1};
        end
    end

    assign completed_inc = completed_reg + 1'b1;
    assign pos_delta     = neg_reg ? {POS_W{1'b1}} : {{(POS_W-1){1'b0}}, 1'b1};

    // Next state for one word
    always_comb
    begin
        moving_next    = moving_reg;
        high_next      = high_reg;
        timer_next     = timer_reg;
        target_next    = target_reg;
        completed_next = completed_reg;
        axis_next      = axis_reg;
        neg_next       = neg_reg;
        limit_next     = limit_reg;
        finish         = 1'b0;
        done           = 1'b0;
        unique case (q_cmd.op)
            OP_TICK:
            begin
                if (moving_reg)
                begin
                    if (!high_reg && timer_reg == '0)
                    begin
                        // Check the limit switch before each pulse
                        if (cfg.limit_enable[axis_reg] && q_cmd.limits[axis_reg])
                        begin
                            limit_next  = 1'b1;
                            moving_next = 1'b0;
                            done        = 1'b1;
                        end
                        else
                        begin
                            high_next  = 1'b1;
                            timer_next = half - 1'b1;
                        end
                    end
                    else if (high_reg)
                    begin
                        if (timer_reg != '0)
                        begin
                            timer_next = timer_reg - 1'b1;
                        end
                        else
                        begin
                            high_next  = 1'b0;
                            timer_next = half - 1'b1;
                            finish     = (half == {{(TIMER_BITS-1){1'b0}}, 1'b1});
                        end
                    end
                    else
                    begin
                        timer_next = timer_reg - 1'b1;
                        finish     = (timer_reg == {{(TIMER_BITS-1){1'b0}}, 1'b1});
                    end
                end
            end
            OP_START:
            begin
                if (!moving_reg)
                begin
                    completed_next = '0;
                    limit_next     = 1'b0;
                    if (cfg.power_on)
                    begin
                        axis_next = q_cmd.sel;
                        neg_next  = q_cmd.neg;
                    end
                    if (!cfg.power_on || q_cmd.mag == '0 || 32'(q_cmd.sel) >= NUM_AXES)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        target_next = q_cmd.mag;
                        high_next   = 1'b0;
                        timer_next  = '0;
                        moving_next = 1'b1;
                    end
                end
            end
            OP_ZERO:
            begin
            end
            OP_NOP:
            begin
            end
        endcase

        // Close out a full pulse
        if (finish)
        begin
            completed_next = completed_inc;
            if (completed_inc >= target_reg)
            begin
                moving_next = 1'b0;
                done        = 1'b1;
            end
        end
    end

    // Position update per axis and readback of the selected axis
    always_comb
    begin
        pos_out = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            pos_next[i] = pos_reg[i];
            if (q_cmd.op == OP_ZERO)
            begin
                pos_next[i] = '0;
            end
            else if (finish && 32'(axis_reg) == i)
            begin
                pos_next[i] = pos_reg[i] + pos_delta;
            end
            if (32'(q_cmd.sel) == i)
            begin
                pos_out = pos_next[i];
            end
        end
    end

    // Hold move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos_reg[i] <= '0;
            end
            moving_reg    <= 1'b0;
            high_reg      <= 1'b0;
            timer_reg     <= '0;
            target_reg    <= '0;
            completed_reg <= '0;
            axis_reg      <= '0;
            neg_reg       <= 1'b0;
            limit_reg     <= 1'b0;
        end
        else if (q_pop)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos_reg[i] <= pos_next[i];
            end
            moving_reg    <= moving_next;
            high_reg      <= high_next;
            timer_reg     <= timer_next;
            target_reg    <= target_next;
            completed_reg <= completed_next;
            axis_reg      <= axis_next;
            neg_reg       <= neg_next;
            limit_reg     <= limit_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register word
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_tdata_reg <= {1'b0, pos_out, completed_next, limit_next, done,
                            moving_next, moving_next, axis_next,
                            cfg.dir_polarity[axis_next] ^ neg_next, high_next};
        end
    end

endmodule

// ----- rtl/core/msp_checker.sv -----
module msp_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [msp_pkg::OUT_W-1:0]   m_tdata
);
    import msp_pkg::*;

    // A stalled output word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // Drive current and busy report the same move state
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4] == m_tdata[5]))
        else $error("drive_full and busy_res disagree");

    // Step line rests low when no move runs
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[5] |-> !m_tdata[0])
        else $error("step line high while idle");

    // A finished move is no longer busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6] |-> !m_tdata[5])
        else $error("move_done while busy");

    // A running move has its limit flag cleared
    a_limit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> !m_tdata[7])
        else $error("limit_hit while busy");

endmodule

bind multi_axis_step_pulse_generator msp_checker u_msp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
